// ----- rtl/rtos_tick_wheel_core_defines.svh -----
// Assertion helpers, clocked on clk and held off during rst.
`ifndef RTOS_TICK_WHEEL_CORE_DEFINES_SVH
`define RTOS_TICK_WHEEL_CORE_DEFINES_SVH

// Same-cycle implication.
`define RTWC_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RTWC_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rtwc_pkg.sv -----
`timescale 1ns / 1ps
package rtwc_pkg;

  localparam int DEF_WHEEL_SIZE = 16;
  localparam int DEF_MAX_TASKS  = 64;
  localparam int RES_DEPTH      = 64;
  localparam int NRW            = 7;
  localparam int CNT_W          = 16;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_REM  = 2'd2;
  localparam logic [1:0] OP_SET  = 2'd3;

  localparam logic [2:0] K_TICK = 3'd0;
  localparam logic [2:0] K_INS  = 3'd1;
  localparam logic [2:0] K_REM  = 3'd2;
  localparam logic [2:0] K_SET  = 3'd3;
  localparam logic [2:0] K_BAD  = 3'd4;

  localparam logic [2:0] TS_RDY          = 3'd0;
  localparam logic [2:0] TS_DLY          = 3'd1;
  localparam logic [2:0] TS_PEND_TO      = 3'd3;
  localparam logic [2:0] TS_SUSP         = 3'd4;
  localparam logic [2:0] TS_DLY_SUSP     = 3'd5;
  localparam logic [2:0] TS_PEND_TO_SUSP = 3'd7;

  localparam logic [2:0] EV_DONE     = 3'd0;
  localparam logic [2:0] EV_DLY_RDY  = 3'd1;
  localparam logic [2:0] EV_DLY_SUSP = 3'd2;
  localparam logic [2:0] EV_TO_RDY   = 3'd3;
  localparam logic [2:0] EV_TO_SUSP  = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  tid;
    logic [31:0] delay;
    logic [2:0]  ns;
  } cmd_t;

  typedef struct packed {
    logic [2:0] ev;
    logic [2:0] to;
  } evt_t;

  function automatic evt_t tick_evt(input logic [2:0] st);
    evt_t e;
    case (st)
      TS_DLY:          e = '{ev: EV_DLY_RDY,  to: TS_RDY};
      TS_PEND_TO:      e = '{ev: EV_TO_RDY,   to: TS_RDY};
      TS_DLY_SUSP:     e = '{ev: EV_DLY_SUSP, to: TS_SUSP};
      TS_PEND_TO_SUSP: e = '{ev: EV_TO_SUSP,  to: TS_SUSP};
      default:         e = '{ev: EV_DONE,     to: TS_RDY};
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/rtos_tick_wheel_core.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Beat contents
// s_axis    in   tuser: opcode[1:0]; tdata: task_id, delay, new_state
// m_axis    out  tdata: task_id_res, event_res, spoke_entries, spoke_peak; tlast: last
//
// Commands queue two deep ahead of a sequencer working one command at a time.
// Set, remove and bad commands need no spoke walk; an insert walks the spoke entries and
// first unlinks a task already listed; a tick visits entries and sends its expiries as
// result beats (one beat if none expire); a wheel size that is not a power of two adds a
// bit-serial spoke remainder step. Task tables share a single registered read port.
// rst is synchronous; spoke lists and task flags are clear after it.
// A stalled m_axis holds the sequencer; s_axis stalls once the queue is full.
module rtos_tick_wheel_core #(
  parameter int WHEEL_SIZE = rtwc_pkg::DEF_WHEEL_SIZE,
  parameter int MAX_TASKS  = rtwc_pkg::DEF_MAX_TASKS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // task_id[5:0], delay[37:6], new_state[40:38]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // task_id_res[5:0], event_res[8:6],
                                     // spoke_entries[15:9], spoke_peak[22:16]
  output logic        m_axis_tlast
);
  import rtwc_pkg::*;

  logic       q_valid, q_pop;
  cmd_t       q_data;
  logic [5:0] o_tid;
  logic [2:0] o_ev;
  logic [6:0] o_ent, o_pk;

  rtwc_front #(.MAX_TASKS(MAX_TASKS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_op    (s_axis_tuser),
    .s_tid   (s_axis_tdata[5:0]),
    .s_delay (s_axis_tdata[37:6]),
    .s_ns    (s_axis_tdata[40:38]),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  rtwc_back #(.WHEEL_SIZE(WHEEL_SIZE), .MAX_TASKS(MAX_TASKS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_tid   (o_tid),
    .m_ev    (o_ev),
    .m_ent   (o_ent),
    .m_pk    (o_pk),
    .m_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, o_pk, o_ent, o_ev, o_tid};

endmodule

// ----- rtl/rtwc_front.sv -----
`timescale 1ns / 1ps
module rtwc_front #(
  parameter int MAX_TASKS = rtwc_pkg::DEF_MAX_TASKS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_valid,
  output logic                s_ready,
  input  logic [1:0]          s_op,
  input  logic [5:0]          s_tid,
  input  logic [31:0]         s_delay,
  input  logic [2:0]          s_ns,
  output logic                q_valid,
  output rtwc_pkg::cmd_t      q_data,
  input  logic                q_pop
);
  import rtwc_pkg::*;

  cmd_t       fq [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push;
  logic       in_range;
  cmd_t       cmd;

  assign in_range = {26'd0, s_tid} < 32'(MAX_TASKS);

  always_comb begin
    cmd.tid   = s_tid;
    cmd.delay = s_delay;
    cmd.ns    = s_ns;
    case (s_op)
      OP_TICK: cmd.kind = K_TICK;
      OP_INS:  cmd.kind = in_range ? K_INS : K_BAD;
      OP_REM:  cmd.kind = in_range ? K_REM : K_BAD;
      OP_SET:  cmd.kind = in_range ? K_SET : K_BAD;
      default: cmd.kind = K_BAD;
    endcase
  end

  assign s_ready = cnt != 2'd2;
  assign push    = s_valid && s_ready;
  assign q_valid = cnt != 2'd0;
  assign q_data  = fq[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      fq[wp] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ----- rtl/rtwc_back.sv -----
`timescale 1ns / 1ps
`include "rtos_tick_wheel_core_defines.svh"
module rtwc_back #(
  parameter int WHEEL_SIZE = rtwc_pkg::DEF_WHEEL_SIZE,
  parameter int MAX_TASKS  = rtwc_pkg::DEF_MAX_TASKS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  rtwc_pkg::cmd_t q_data,
  output logic           q_pop,
  output logic           m_valid,
  input  logic           m_ready,
  output logic [5:0]     m_tid,
  output logic [2:0]     m_ev,
  output logic [6:0]     m_ent,
  output logic [6:0]     m_pk,
  output logic           m_last
);
  import rtwc_pkg::*;

  localparam int  TW   = $clog2(MAX_TASKS);
  localparam int  LW   = TW + 1;
  localparam int  SW   = (WHEEL_SIZE > 1) ? $clog2(WHEEL_SIZE) : 1;
  localparam int  GW   = $clog2(MAX_TASKS + 1);
  localparam bit  POW2 = (WHEEL_SIZE & (WHEEL_SIZE - 1)) == 0;
  localparam logic [LW-1:0] LNULL = {1'b1, {TW{1'b0}}};

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_MOD     = 5'd1;
  localparam logic [4:0] S_TK_HEAD = 5'd2;
  localparam logic [4:0] S_TW0     = 5'd3;
  localparam logic [4:0] S_TW1     = 5'd4;
  localparam logic [4:0] S_FIN     = 5'd5;
  localparam logic [4:0] S_EM_RD   = 5'd6;
  localparam logic [4:0] S_EM_WT   = 5'd7;
  localparam logic [4:0] S_IN_HEAD = 5'd8;
  localparam logic [4:0] S_UL_LT   = 5'd9;
  localparam logic [4:0] S_UL1     = 5'd10;
  localparam logic [4:0] S_UL2     = 5'd11;
  localparam logic [4:0] S_IN_PUT  = 5'd12;
  localparam logic [4:0] S_IW0     = 5'd13;
  localparam logic [4:0] S_IW1     = 5'd14;
  localparam logic [4:0] S_PL0     = 5'd15;
  localparam logic [4:0] S_PL1     = 5'd16;
  localparam logic [4:0] S_HS_WT   = 5'd17;
  localparam logic [4:0] S_RES     = 5'd18;

  // control
  logic [4:0]  st, st_next, ret, mod_ret;
  logic [31:0] counter, mval, msh, mnew;
  logic [4:0]  mod_cnt;
  logic [SW:0] mod_r, r_step, r_sh;
  logic [SW-1:0] sp, sp_p2;
  logic [LW-1:0] cur, prv;
  logic [GW-1:0] guard;
  logic [NRW-1:0] nres, ek;
  logic        zero_res;
  logic [5:0]  rtid;
  logic [TW-1:0] ul_t;
  logic [SW-1:0] ul_s;
  logic [LW-1:0] ul_p, ul_n;
  cmd_t        c;
  logic [TW-1:0] idx, qidx, curi;

  // per-task state and expiry result buffer
  logic [31:0]   mt_mem [MAX_TASKS];
  logic [LW-1:0] nx_mem [MAX_TASKS];
  logic [LW-1:0] pv_mem [MAX_TASKS];
  logic [SW-1:0] hs_mem [MAX_TASKS];
  logic [2:0]    ts_mem [MAX_TASKS];
  logic [8:0]    rb_mem [RES_DEPTH];
  logic [MAX_TASKS-1:0] ts_vld, inw;
  logic [31:0]   mt_rd;
  logic [LW-1:0] nx_rd, pv_rd;
  logic [SW-1:0] hs_rd;
  logic [2:0]    ts_rd;
  logic          ts_v_rd;
  logic [8:0]    rb_rd;
  logic [TW-1:0] ra;

  // per-spoke state
  logic [LW-1:0]    head_q [WHEEL_SIZE];
  logic [CNT_W-1:0] cnt_q  [WHEEL_SIZE];
  logic [CNT_W-1:0] mx_q   [WHEEL_SIZE];
  logic [CNT_W-1:0] cnt_inc;

  // write strobes
  logic mt_we, nx_we, pv_we, hs_we, ts_we, rb_we, inw_we, head_we, cnt_we, mx_we;
  logic [TW-1:0] mt_wi, nx_wi, pv_wi, ts_wi, inw_wi;
  logic [31:0]   mt_wd;
  logic [LW-1:0] nx_wd, pv_wd, head_wd;
  logic [2:0]    ts_wd;
  logic          inw_wd;
  logic [SW-1:0] head_wi, cnt_wi;
  logic [CNT_W-1:0] cnt_wd;

  logic        out_free, o_load, ld_last, tw_stop, due, ins_stop;
  logic [5:0]  ld_tid;
  logic [2:0]  ld_ev, tstate;
  evt_t        evt;
  logic [31:0] rem;

  assign idx      = TW'(c.tid);
  assign qidx     = TW'(q_data.tid);
  assign curi     = cur[TW-1:0];
  assign out_free = !m_valid || m_ready;
  assign mnew     = (q_data.kind == K_TICK) ? counter + 32'd1 : counter + q_data.delay;
  assign sp_p2    = SW'(mval & 32'(WHEEL_SIZE - 1));
  assign r_sh     = {mod_r[SW-1:0], msh[31]};
  assign r_step   = (r_sh >= (SW+1)'(WHEEL_SIZE)) ? r_sh - (SW+1)'(WHEEL_SIZE) : r_sh;
  assign tw_stop  = cur[TW] || guard == GW'(MAX_TASKS) || nres == NRW'(RES_DEPTH);
  assign tstate   = ts_v_rd ? ts_rd : TS_RDY;
  assign evt      = tick_evt(tstate);
  assign due      = mt_rd == counter;
  assign rem      = mt_rd - counter;
  assign ins_stop = c.delay <= rem;
  assign cnt_inc  = cnt_q[sp] + CNT_W'(1);

  always_comb begin
    st_next = st;
    q_pop   = 1'b0;
    ra      = curi;
    o_load  = 1'b0;
    ld_last = 1'b1;
    ld_tid  = rtid;
    ld_ev   = EV_DONE;
    mt_we = 1'b0; mt_wi = ul_t; mt_wd = 32'd0;
    nx_we = 1'b0; nx_wi = ul_t; nx_wd = LNULL;
    pv_we = 1'b0; pv_wi = ul_t; pv_wd = LNULL;
    hs_we = 1'b0;
    ts_we = 1'b0; ts_wi = curi; ts_wd = evt.to;
    rb_we = 1'b0;
    inw_we = 1'b0; inw_wi = ul_t; inw_wd = 1'b0;
    head_we = 1'b0; head_wi = ul_s; head_wd = ul_n;
    cnt_we = 1'b0; cnt_wi = ul_s; cnt_wd = cnt_q[ul_s] - CNT_W'(1);
    mx_we = 1'b0;
    case (st)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          ra    = qidx;
          case (q_data.kind)
            K_TICK, K_INS: st_next = S_MOD;
            K_REM: st_next = inw[qidx] ? S_UL_LT : S_RES;
            K_SET: begin
              ts_we   = 1'b1;
              ts_wi   = qidx;
              ts_wd   = q_data.ns;
              st_next = inw[qidx] ? S_HS_WT : S_RES;
            end
            default: st_next = S_RES;
          endcase
        end
      end
      S_MOD: begin
        if (POW2 || mod_cnt == 5'd31) begin
          st_next = mod_ret;
        end
      end
      S_TK_HEAD: st_next = S_TW0;
      S_TW0: begin
        st_next = tw_stop ? S_FIN : S_TW1;
      end
      S_TW1: begin
        st_next = S_TW0;
        if (evt.ev != EV_DONE) begin
          if (due) begin
            ts_we = 1'b1;
            rb_we = 1'b1;
            if (inw[curi]) begin
              st_next = S_UL1;
            end
          end else begin
            st_next = S_FIN;
          end
        end
      end
      S_FIN: st_next = (nres == '0) ? S_RES : S_EM_RD;
      S_EM_RD: st_next = S_EM_WT;
      S_EM_WT: begin
        ld_tid  = rb_rd[8:3];
        ld_ev   = rb_rd[2:0];
        ld_last = ek == nres - NRW'(1);
        if (out_free) begin
          o_load  = 1'b1;
          st_next = ld_last ? S_IDLE : S_EM_RD;
        end
      end
      S_IN_HEAD: begin
        ra      = idx;
        st_next = inw[idx] ? S_UL_LT : S_IN_PUT;
      end
      S_UL_LT: st_next = S_UL1;
      S_UL1: begin
        if (ul_p[TW]) begin
          head_we = 1'b1;
        end else begin
          nx_we = 1'b1;
          nx_wi = ul_p[TW-1:0];
          nx_wd = ul_n;
        end
        if (!ul_n[TW]) begin
          pv_we = 1'b1;
          pv_wi = ul_n[TW-1:0];
          pv_wd = ul_p;
        end
        inw_we  = 1'b1;
        cnt_we  = cnt_q[ul_s] != '0;
        st_next = S_UL2;
      end
      S_UL2: begin
        nx_we   = 1'b1;
        pv_we   = 1'b1;
        mt_we   = 1'b1;
        st_next = ret;
      end
      S_IN_PUT: begin
        mt_we   = 1'b1;
        mt_wi   = idx;
        mt_wd   = mval;
        st_next = S_IW0;
      end
      S_IW0: begin
        st_next = (cur[TW] || guard == GW'(MAX_TASKS)) ? S_PL0 : S_IW1;
      end
      S_IW1: st_next = ins_stop ? S_PL0 : S_IW0;
      S_PL0: begin
        nx_we = 1'b1; nx_wi = idx; nx_wd = cur;
        pv_we = 1'b1; pv_wi = idx; pv_wd = prv;
        hs_we = 1'b1;
        inw_we = 1'b1; inw_wi = idx; inw_wd = 1'b1;
        st_next = S_PL1;
      end
      S_PL1: begin
        if (prv[TW]) begin
          head_we = 1'b1;
          head_wi = sp;
          head_wd = {1'b0, idx};
        end else begin
          nx_we = 1'b1;
          nx_wi = prv[TW-1:0];
          nx_wd = {1'b0, idx};
        end
        if (!cur[TW]) begin
          pv_we = 1'b1;
          pv_wi = curi;
          pv_wd = {1'b0, idx};
        end
        cnt_we  = 1'b1;
        cnt_wi  = sp;
        cnt_wd  = cnt_inc;
        mx_we   = mx_q[sp] < cnt_inc;
        st_next = S_RES;
      end
      S_HS_WT: st_next = S_RES;
      S_RES: begin
        if (out_free) begin
          o_load  = 1'b1;
          st_next = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  // task memories and expiry result buffer
  always_ff @(posedge clk) begin
    if (mt_we) mt_mem[mt_wi] <= mt_wd;
    if (nx_we) nx_mem[nx_wi] <= nx_wd;
    if (pv_we) pv_mem[pv_wi] <= pv_wd;
    if (hs_we) hs_mem[idx] <= sp;
    if (ts_we) ts_mem[ts_wi] <= ts_wd;
    if (rb_we) rb_mem[nres[5:0]] <= {6'(curi), evt.ev};
    mt_rd   <= mt_mem[ra];
    nx_rd   <= nx_mem[ra];
    pv_rd   <= pv_mem[ra];
    hs_rd   <= hs_mem[ra];
    ts_rd   <= ts_mem[ra];
    ts_v_rd <= ts_vld[ra];
    rb_rd   <= rb_mem[ek[5:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ts_vld <= '0;
      inw    <= '0;
      for (int i = 0; i < WHEEL_SIZE; i++) begin
        head_q[i] <= LNULL;
        cnt_q[i]  <= '0;
        mx_q[i]   <= '0;
      end
    end else begin
      if (ts_we) ts_vld[ts_wi] <= 1'b1;
      if (inw_we) inw[inw_wi] <= inw_wd;
      if (head_we) head_q[head_wi] <= head_wd;
      if (cnt_we) cnt_q[cnt_wi] <= cnt_wd;
      if (mx_we) mx_q[sp] <= cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= S_IDLE;
      counter <= '0;
      m_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (o_load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      if (st == S_IDLE && q_valid && q_data.kind == K_TICK) begin
        counter <= counter + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      m_tid  <= ld_tid;
      m_ev   <= ld_ev;
      m_ent  <= zero_res ? 7'd0 : cnt_q[sp][6:0];
      m_pk   <= zero_res ? 7'd0 : mx_q[sp][6:0];
      m_last <= ld_last;
    end
    case (st)
      S_IDLE: begin
        if (q_valid) begin
          c        <= q_data;
          rtid     <= (q_data.kind == K_TICK) ? 6'd0 : q_data.tid;
          zero_res <= (q_data.kind == K_BAD) ||
                      (q_data.kind != K_TICK && q_data.kind != K_INS && !inw[qidx]);
          mod_ret  <= (q_data.kind == K_TICK) ? S_TK_HEAD : S_IN_HEAD;
          mval     <= mnew;
          msh      <= mnew;
          mod_r    <= '0;
          mod_cnt  <= '0;
          ul_t     <= qidx;
          ret      <= S_RES;
        end
      end
      S_MOD: begin
        if (POW2) begin
          sp <= sp_p2;
        end else begin
          mod_r   <= r_step;
          msh     <= {msh[30:0], 1'b0};
          mod_cnt <= mod_cnt + 5'd1;
          sp      <= r_step[SW-1:0];
        end
      end
      S_TK_HEAD: begin
        cur   <= head_q[sp];
        guard <= '0;
        nres  <= '0;
      end
      S_TW1: begin
        guard <= guard + GW'(1);
        cur   <= nx_rd;
        if (evt.ev != EV_DONE && due) begin
          nres <= nres + NRW'(1);
          ul_t <= curi;
          ul_s <= hs_rd;
          ul_p <= pv_rd;
          ul_n <= nx_rd;
          ret  <= S_TW0;
        end
      end
      S_FIN: ek <= '0;
      S_EM_WT: begin
        if (out_free) ek <= ek + NRW'(1);
      end
      S_IN_HEAD: begin
        cur   <= head_q[sp];
        prv   <= LNULL;
        guard <= '0;
        ul_t  <= idx;
        ret   <= S_IN_PUT;
      end
      S_UL_LT: begin
        ul_s <= hs_rd;
        ul_p <= pv_rd;
        ul_n <= nx_rd;
        if (c.kind == K_REM) sp <= hs_rd;
      end
      S_IW0: begin
        if (guard == GW'(MAX_TASKS)) cur <= LNULL;
      end
      S_IW1: begin
        if (!ins_stop) begin
          prv   <= cur;
          cur   <= nx_rd;
          guard <= guard + GW'(1);
        end
      end
      S_HS_WT: sp <= hs_rd;
      default: begin
      end
    endcase
  end

  `RTWC_AST_NOW(a_walk_bound, st == S_TW1, guard < GW'(MAX_TASKS), "walk beyond task bound")
  `RTWC_AST_NXT(a_pop_busy, q_pop, st != S_IDLE, "command taken but sequencer idle")
  `RTWC_AST_NOW(a_place_listed, st == S_PL1, inw[idx], "placing a task not marked listed")
  `RTWC_AST_NXT(a_last_idle, o_load && ld_last, st == S_IDLE, "final beat did not end command")
  `RTWC_AST_NOW(a_res_bound, st == S_FIN, nres <= NRW'(RES_DEPTH), "expiry buffer overrun")

endmodule

// ----- sim/rtos_tick_wheel_core_chk.sv -----
`timescale 1ns / 1ps
module rtos_tick_wheel_core_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          errors,
  output int          pending
);
  import rtwc_pkg::*;

  localparam int NSPK = 16;
  localparam int NTSK = 64;
  localparam int NIL  = -1;

  typedef struct packed {
    logic [5:0] tid;
    logic [2:0] ev;
    logic [6:0] ent;
    logic [6:0] peak;
    logic       lst;
  } wheel_res_t;

  logic [31:0] now_ticks;
  logic [31:0] due_at [NTSK];
  int          fwd [NTSK];
  int          bwd [NTSK];
  int          spk_of [NTSK];
  bit          linked [NTSK];
  logic [2:0]  tstate [NTSK];
  int          head [NSPK];
  int          cnt [NSPK];
  int          peak [NSPK];
  wheel_res_t  due_q [$];

  initial begin
    errors = 0;
    now_ticks = '0;
    for (int i = 0; i < NTSK; i++) begin
      due_at[i] = '0; fwd[i] = NIL; bwd[i] = NIL; spk_of[i] = 0;
      linked[i] = 0; tstate[i] = TS_RDY;
    end
    for (int i = 0; i < NSPK; i++) begin
      head[i] = NIL; cnt[i] = 0; peak[i] = 0;
    end
  end

  assign pending = due_q.size();

  function automatic void detach(int t);
    int s;
    if (!linked[t]) return;
    s = spk_of[t];
    if (bwd[t] == NIL) head[s] = fwd[t];
    else fwd[bwd[t]] = fwd[t];
    if (fwd[t] != NIL) bwd[fwd[t]] = bwd[t];
    fwd[t] = NIL; bwd[t] = NIL; linked[t] = 0; due_at[t] = '0;
    if (cnt[s] > 0) cnt[s]--;
  endfunction

  function automatic void push_res(int t, logic [2:0] ev, int s, bit lst, bit zero);
    wheel_res_t r;
    r.tid = t[5:0]; r.ev = ev;
    r.ent = zero ? 7'd0 : cnt[s][6:0];
    r.peak = zero ? 7'd0 : peak[s][6:0];
    r.lst = lst;
    due_q.push_back(r);
  endfunction

  function automatic void predict_cmd(logic [1:0] op, int t, logic [31:0] dly,
                                      logic [2:0] ns);
    int s, cur, prv, nxt, n, g;
    logic [31:0] m;
    int ids [$];
    logic [2:0] evs [$];
    logic [2:0] ev, to;
    bit stop;
    case (op)
      OP_TICK: begin
        now_ticks++;
        s = int'(now_ticks % NSPK);
        cur = head[s]; g = 0; stop = 0;
        while (!stop && cur != NIL && g < NTSK) begin
          nxt = fwd[cur]; g++;
          ev = EV_DONE; to = TS_RDY;
          case (tstate[cur])
            TS_DLY:          ev = EV_DLY_RDY;
            TS_PEND_TO:      ev = EV_TO_RDY;
            TS_DLY_SUSP:     begin ev = EV_DLY_SUSP; to = TS_SUSP; end
            TS_PEND_TO_SUSP: begin ev = EV_TO_SUSP; to = TS_SUSP; end
            default: ;
          endcase
          if (ev != EV_DONE) begin
            if (due_at[cur] == now_ticks) begin
              tstate[cur] = to; detach(cur);
              ids.push_back(cur); evs.push_back(ev);
            end else stop = 1;
          end
          cur = nxt;
        end
        n = ids.size();
        if (n == 0) push_res(0, EV_DONE, s, 1, 0);
        for (int k = 0; k < n; k++) push_res(ids[k], evs[k], s, k == n - 1, 0);
      end
      OP_INS: begin
        m = now_ticks + dly;
        s = int'(m % NSPK);
        cur = head[s]; prv = NIL; g = 0;
        detach(t);
        due_at[t] = m;
        while (cur != NIL && g < NTSK) begin
          if (dly <= due_at[cur] - now_ticks) break;
          prv = cur; cur = fwd[cur]; g++;
        end
        if (g >= NTSK) cur = NIL;
        bwd[t] = prv; fwd[t] = cur;
        if (prv == NIL) head[s] = t; else fwd[prv] = t;
        if (cur != NIL) bwd[cur] = t;
        spk_of[t] = s; linked[t] = 1;
        cnt[s]++;
        if (peak[s] < cnt[s]) peak[s] = cnt[s];
        push_res(t, EV_DONE, s, 1, 0);
      end
      OP_REM: begin
        if (linked[t]) begin
          s = spk_of[t]; detach(t); push_res(t, EV_DONE, s, 1, 0);
        end else push_res(t, EV_DONE, 0, 1, 1);
      end
      default: begin
        tstate[t] = ns;
        if (linked[t]) push_res(t, EV_DONE, spk_of[t], 1, 0);
        else push_res(t, EV_DONE, 0, 1, 1);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    wheel_res_t got, exp_r;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        predict_cmd(s_axis_tuser, int'(s_axis_tdata[5:0]), s_axis_tdata[37:6],
                    s_axis_tdata[40:38]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.tid = m_axis_tdata[5:0]; got.ev = m_axis_tdata[8:6];
        got.ent = m_axis_tdata[15:9]; got.peak = m_axis_tdata[22:16];
        got.lst = m_axis_tlast;
        if (due_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat %h last %b", $time, m_axis_tdata, m_axis_tlast);
        end else begin
          exp_r = due_q.pop_front();
          if (got !== exp_r) begin
            errors++;
            $display("%0t: mismatch exp tid %0d ev %0d ent %0d peak %0d last %0b",
                     $time, exp_r.tid, exp_r.ev, exp_r.ent, exp_r.peak, exp_r.lst);
            $display("%0t:          got tid %0d ev %0d ent %0d peak %0d last %0b",
                     $time, got.tid, got.ev, got.ent, got.peak, got.lst);
          end
        end
      end
    end
  end
endmodule

// ----- sim/rtos_tick_wheel_core_tb.sv -----
`timescale 1ns / 1ps
module rtos_tick_wheel_core_tb;
  import rtwc_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = OP_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          errors;
  int          pending;

  always #1 clk = ~clk;

  rtos_tick_wheel_core u_top (.*);

  rtos_tick_wheel_core_chk u_chk (.*);

  task automatic send_cmd(logic [1:0] op, logic [5:0] tid, logic [31:0] dly,
                          logic [2:0] ns);
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, ns, dly, tid};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic gap;
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  function automatic logic [2:0] timed_state();
    logic [2:0] v [4] = '{TS_DLY, TS_PEND_TO, TS_DLY_SUSP, TS_PEND_TO_SUSP};
    return v[$urandom_range(0, 3)];
  endfunction

  // receiver: phases of full rate, light and heavy stall
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(10, 80)) begin
        @(negedge clk);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 3) != 0;
          default: m_axis_tready <= $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int t, d;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed
    send_cmd(OP_TICK, 6'd0, 32'd0, TS_RDY);
    send_cmd(OP_REM, 6'd5, 32'd0, TS_RDY);
    send_cmd(OP_SET, 6'd63, 32'd0, 3'd7);
    send_cmd(OP_INS, 6'd63, 32'hFFFF_FFFF, TS_RDY);
    send_cmd(OP_SET, 6'd63, 32'hFFFF_FFFF, 3'd7);
    send_cmd(OP_SET, 6'd1, 32'd0, TS_DLY);
    send_cmd(OP_INS, 6'd1, 32'd2, TS_RDY);
    send_cmd(OP_SET, 6'd2, 32'd0, 3'd2);
    send_cmd(OP_INS, 6'd2, 32'd2, TS_RDY);
    send_cmd(OP_SET, 6'd3, 32'd0, TS_PEND_TO);
    send_cmd(OP_INS, 6'd3, 32'd2, TS_RDY);
    send_cmd(OP_SET, 6'd4, 32'd0, TS_DLY_SUSP);
    send_cmd(OP_INS, 6'd4, 32'd18, TS_RDY);
    send_cmd(OP_SET, 6'd6, 32'd0, TS_PEND_TO_SUSP);
    send_cmd(OP_INS, 6'd6, 32'd0, TS_RDY);
    send_cmd(OP_INS, 6'd1, 32'd2, TS_RDY);
    send_cmd(OP_TICK, 6'd0, 32'd0, TS_RDY);
    send_cmd(OP_TICK, 6'd0, 32'd0, TS_RDY);
    send_cmd(OP_SET, 6'd7, 32'd0, 3'd6);
    send_cmd(OP_INS, 6'd7, 32'd16, 3'd0);
    send_cmd(OP_REM, 6'd7, 32'd0, TS_RDY);
    send_cmd(OP_REM, 6'd7, 32'd0, TS_RDY);
    // random: mix of ticks, inserts, removes and state sets, task ids mostly small
    for (int i = 0; i < 350; i++) begin
      t = $urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 11);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_cmd(OP_TICK, 6'($urandom), 32'($urandom), 3'($urandom));
        4, 5, 6: begin
          d = $urandom_range(0, 19) == 0 ? $urandom : $urandom_range(0, 40);
          send_cmd(OP_INS, 6'(t), 32'(d), 3'($urandom));
        end
        7: send_cmd(OP_REM, 6'(t), 32'($urandom), 3'($urandom));
        default: send_cmd(OP_SET, 6'(t), 32'($urandom),
                          $urandom_range(0, 2) == 0 ? 3'($urandom) : timed_state());
      endcase
      gap();
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
